// File: hdl/pdb_pkg.sv
// pdb_pkg: types, constants and helpers for the pixel depth back-projection block
// no dependencies; used by pixel_depth_backprojection_top
package pdb_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int COMP_BITS  = 21;
    localparam int CFG_W      = 63;
    localparam int APB_DW     = 64;
    localparam int APB_AW     = 5;
    localparam int COL_W      = 12;
    localparam int DIST_W     = 32;
    localparam int WORLD_W    = 32;

    typedef enum logic [1:0] {
        REG_ORIGIN = 2'd0,
        REG_CORNER = 2'd1,
        REG_STEP_X = 2'd2,
        REG_STEP_Y = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [COL_W-1:0]  row;
        logic [DIST_W-1:0] distance;
    } t_in_item;

    typedef struct packed {
        logic signed [WORLD_W-1:0] world_x;
        logic signed [WORLD_W-1:0] world_y;
        logic signed [WORLD_W-1:0] world_z;
    } t_out_item;

    // component k of a packed x,y,z register
    function automatic logic signed [COMP_BITS-1:0] comp(input logic [CFG_W-1:0] v,
                                                        input int k);
        return $signed(v[k*COMP_BITS +: COMP_BITS]);
    endfunction

endpackage

// File: hdl/pixel_depth_backprojection_top.sv
// pixel_depth_backprojection_top: pipelined pixel/depth to world point back-projection
// depends on pdb_pkg (types, register indexes, component extraction)
//
//  channel   direction  handshake                       payload
//  input     in         i_in_valid / o_in_ready         i_in_item  (column, row, distance)
//  output    out        o_out_valid / i_out_ready       o_out_item (world_x, world_y, world_z)
//  config    in         psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//
// 25 register stages: one item per cycle while i_out_ready does not stall the output
// depth is set by the 8-stage square root and the 8-stage divider (4 digits per stage, 3 in the last divider stage)
// reset clears the configuration registers and all stage valid bits
// each stage holds while full and blocked, so empty stages keep accepting items
module pixel_depth_backprojection_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pdb_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pdb_pkg::t_out_item              o_out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pdb_pkg::APB_AW-1:0]      paddr,
    input  logic [pdb_pkg::APB_DW-1:0]      pwdata,
    output logic [pdb_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    localparam int PB      = pdb_pkg::PIXEL_BITS;
    localparam int CW      = pdb_pkg::COMP_BITS;
    localparam int CX_W    = PB + 2;
    localparam int PROD_W  = CX_W + CW;
    localparam int D_W     = PROD_W + 2;
    localparam int MAG_W   = D_W - 1;
    localparam int SH_W    = $clog2(MAG_W);
    localparam int NM_W    = 31;
    localparam int SQ_W    = 2 * NM_W;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int SREM_W  = ROOT_W + 4;
    localparam int QU_W    = 31;
    localparam int DREM_W  = ROOT_W + 1;
    localparam int MUL_W   = QU_W + pdb_pkg::DIST_W;
    localparam int RND_SH  = 30;
    localparam int RND_W   = MUL_W + 1 - RND_SH;
    localparam int RAY_W   = RND_W + 1;
    localparam int ORG_SH  = 6;
    localparam int WS_W    = RAY_W + 1;
    localparam int WW      = pdb_pkg::WORLD_W;

    localparam int SQRT_ST  = 8;
    localparam int SQ_STEPS = ROOT_W / SQRT_ST;
    localparam int DIV_ST   = 8;
    localparam int DV_STEPS = (QU_W + DIV_ST - 1) / DIV_ST;

    localparam int S_PROD  = 0;
    localparam int S_DIFF  = 1;
    localparam int S_NORM0 = 2;
    localparam int S_NORM1 = 3;
    localparam int S_SQ    = 4;
    localparam int S_SUM   = 5;
    localparam int S_SQRT  = 6;
    localparam int S_DIV   = S_SQRT + SQRT_ST;
    localparam int S_MUL   = S_DIV + DIV_ST;
    localparam int S_RND   = S_MUL + 1;
    localparam int S_OUT   = S_RND + 1;
    localparam int NS      = S_OUT + 1;

    localparam int APB_IDX_LO = 3;
    localparam int APB_IDX_HI = 4;

    localparam logic [SH_W-1:0] NORM_TOP = SH_W'(NM_W - 1);

    typedef struct packed {
        logic [pdb_pkg::DIST_W-1:0]  depth;
        logic [2:0]                  neg;
        logic                        zero;
        logic [2:0][NM_W-1:0]        nm;
    } t_side;

    // configuration
    logic [pdb_pkg::CFG_W-1:0] r_cfg [4];
    pdb_pkg::t_reg_idx         w_widx;

    assign w_widx = pdb_pkg::t_reg_idx'(paddr[APB_IDX_HI:APB_IDX_LO]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            r_cfg[w_widx] <= pwdata[pdb_pkg::CFG_W-1:0];
        end
    end

    assign prdata = {1'b0, r_cfg[w_widx]};
    assign pready = 1'b1;

    // stage handshake
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_rdy;

    always_comb begin
        w_rdy[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[S_OUT];

    // data registers
    t_side                     r_side [NS];
    t_side                     n_side [NS];
    logic signed [PROD_W-1:0]  r_px [3];
    logic signed [PROD_W-1:0]  r_py [3];
    logic signed [PROD_W-1:0]  n_px [3];
    logic signed [PROD_W-1:0]  n_py [3];
    logic [MAG_W-1:0]          r_mag [3];
    logic [MAG_W-1:0]          n_mag [3];
    logic [2:0]                n_neg;
    logic [MAG_W-1:0]          r_mag2 [3];
    logic                      r_shr;
    logic [SH_W-1:0]           r_sha;
    logic                      n_shr;
    logic [SH_W-1:0]           n_sha;
    logic                      n_zero;
    logic [2:0][NM_W-1:0]      n_nm;
    logic [SQ_W-1:0]           r_sq [3];
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          r_sqn [SQRT_ST];
    logic [SREM_W-1:0]         r_sqr [SQRT_ST];
    logic [ROOT_W-1:0]         r_sqq [SQRT_ST];
    logic [SUM_W-1:0]          n_sqn [SQRT_ST];
    logic [SREM_W-1:0]         n_sqr [SQRT_ST];
    logic [ROOT_W-1:0]         n_sqq [SQRT_ST];
    logic [ROOT_W-1:0]         r_dlen [DIV_ST];
    logic [DREM_W-1:0]         r_drem [DIV_ST][3];
    logic [QU_W-1:0]           r_dq [DIV_ST][3];
    logic [ROOT_W-1:0]         n_dlen [DIV_ST];
    logic [DREM_W-1:0]         n_drem [DIV_ST][3];
    logic [QU_W-1:0]           n_dq [DIV_ST][3];
    logic [MUL_W-1:0]          r_prod [3];
    logic signed [RAY_W-1:0]   r_ray [3];
    logic signed [RAY_W-1:0]   n_ray [3];
    logic signed [WW-1:0]      n_world [3];
    pdb_pkg::t_out_item        r_out;

    // offset products and normalisation
    always_comb begin
        logic [PB:0]              v_cx;
        logic [PB:0]              v_cy;
        logic signed [D_W-1:0]    v_d;
        logic [MAG_W-1:0]         v_mx;
        logic [SH_W-1:0]          v_pos;
        v_cx = {PB'(i_in_item.column), 1'b1};
        v_cy = {PB'(i_in_item.row), 1'b1};
        for (int k = 0; k < 3; k++) begin
            n_px[k] = PROD_W'($signed({1'b0, v_cx}))
                    * PROD_W'(pdb_pkg::comp(r_cfg[pdb_pkg::REG_STEP_X], k));
            n_py[k] = PROD_W'($signed({1'b0, v_cy}))
                    * PROD_W'(pdb_pkg::comp(r_cfg[pdb_pkg::REG_STEP_Y], k));
            v_d = (D_W'(pdb_pkg::comp(r_cfg[pdb_pkg::REG_CORNER], k)) <<< 10)
                + D_W'(r_px[k]) + D_W'(r_py[k]);
            n_neg[k] = v_d[D_W-1];
            n_mag[k] = n_neg[k] ? MAG_W'(-v_d) : MAG_W'(v_d);
        end
        v_mx = r_mag[0];
        if (r_mag[1] > v_mx) begin
            v_mx = r_mag[1];
        end
        if (r_mag[2] > v_mx) begin
            v_mx = r_mag[2];
        end
        v_pos = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v_mx[i]) begin
                v_pos = SH_W'(i);
            end
        end
        n_zero = (v_mx == '0);
        n_shr  = (v_pos >= NORM_TOP);
        n_sha  = n_shr ? (v_pos - NORM_TOP) : (NORM_TOP - v_pos);
        for (int k = 0; k < 3; k++) begin
            n_nm[k] = r_shr ? NM_W'(r_mag2[k] >> r_sha) : NM_W'(r_mag2[k] << r_sha);
        end
    end

    // side data travelling with the item
    always_comb begin
        n_side[0]       = '0;
        n_side[0].depth = i_in_item.distance;
        for (int k = 1; k < NS; k++) begin
            n_side[k] = r_side[k-1];
            if (k == S_DIFF) begin
                n_side[k].neg = n_neg;
            end
            if (k == S_NORM0) begin
                n_side[k].zero = n_zero;
            end
            if (k == S_NORM1) begin
                n_side[k].nm = n_nm;
            end
        end
    end

    // square root, two bits of radicand per digit
    always_comb begin
        logic [SUM_W-1:0]  v_n;
        logic [SREM_W-1:0] v_r;
        logic [ROOT_W-1:0] v_q;
        logic [SREM_W-1:0] v_t;
        for (int j = 0; j < SQRT_ST; j++) begin
            if (j == 0) begin
                v_n = r_sum;
                v_r = '0;
                v_q = '0;
            end else begin
                v_n = r_sqn[j-1];
                v_r = r_sqr[j-1];
                v_q = r_sqq[j-1];
            end
            for (int t = 0; t < SQ_STEPS; t++) begin
                v_r = {v_r[SREM_W-3:0], v_n[SUM_W-1 -: 2]};
                v_n = v_n << 2;
                v_t = SREM_W'({v_q, 2'b01});
                if (v_r >= v_t) begin
                    v_r = v_r - v_t;
                    v_q = {v_q[ROOT_W-2:0], 1'b1};
                end else begin
                    v_q = {v_q[ROOT_W-2:0], 1'b0};
                end
            end
            n_sqn[j] = v_n;
            n_sqr[j] = v_r;
            n_sqq[j] = v_q;
        end
    end

    // unit vector divide, one quotient bit per step
    always_comb begin
        logic [ROOT_W-1:0] v_len;
        logic [DREM_W-1:0] v_rem;
        logic [QU_W-1:0]   v_q;
        for (int j = 0; j < DIV_ST; j++) begin
            v_len = (j == 0) ? r_sqq[SQRT_ST-1] : r_dlen[j-1];
            n_dlen[j] = v_len;
            for (int k = 0; k < 3; k++) begin
                if (j == 0) begin
                    v_rem = DREM_W'(r_side[S_DIV-1].nm[k]);
                    v_q   = '0;
                end else begin
                    v_rem = r_drem[j-1][k];
                    v_q   = r_dq[j-1][k];
                end
                for (int t = 0; t < DV_STEPS; t++) begin
                    if (j * DV_STEPS + t < QU_W) begin
                        if (v_rem >= DREM_W'(v_len)) begin
                            v_rem = v_rem - DREM_W'(v_len);
                            v_q   = {v_q[QU_W-2:0], 1'b1};
                        end else begin
                            v_q   = {v_q[QU_W-2:0], 1'b0};
                        end
                        v_rem = v_rem << 1;
                    end
                end
                n_drem[j][k] = v_rem;
                n_dq[j][k]   = v_q;
            end
        end
    end

    // rounding, sign, origin and saturation
    always_comb begin
        logic [RND_W-1:0]       v_rnd;
        logic signed [WS_W-1:0] v_w;
        for (int k = 0; k < 3; k++) begin
            v_rnd = RND_W'(((MUL_W + 1)'(r_prod[k]) + ((MUL_W + 1)'(1) << (RND_SH - 1)))
                    >> RND_SH);
            if (r_side[S_MUL].zero) begin
                n_ray[k] = '0;
            end else if (r_side[S_MUL].neg[k]) begin
                n_ray[k] = -$signed({1'b0, v_rnd});
            end else begin
                n_ray[k] = $signed({1'b0, v_rnd});
            end
            v_w = (WS_W'(pdb_pkg::comp(r_cfg[pdb_pkg::REG_ORIGIN], k)) <<< ORG_SH)
                + WS_W'(r_ray[k]);
            if (!v_w[WS_W-1] && (|v_w[WS_W-2:WW-1])) begin
                n_world[k] = {1'b0, {(WW - 1){1'b1}}};
            end else if (v_w[WS_W-1] && !(&v_w[WS_W-2:WW-1])) begin
                n_world[k] = {1'b1, {(WW - 1){1'b0}}};
            end else begin
                n_world[k] = v_w[WW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_rdy[k]) begin
                r_side[k] <= n_side[k];
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (w_rdy[S_PROD]) begin
                r_px[k] <= n_px[k];
                r_py[k] <= n_py[k];
            end
            if (w_rdy[S_DIFF]) begin
                r_mag[k] <= n_mag[k];
            end
            if (w_rdy[S_NORM0]) begin
                r_mag2[k] <= r_mag[k];
            end
            if (w_rdy[S_SQ]) begin
                r_sq[k] <= SQ_W'(r_side[S_NORM1].nm[k]) * SQ_W'(r_side[S_NORM1].nm[k]);
            end
            if (w_rdy[S_MUL]) begin
                r_prod[k] <= MUL_W'(r_dq[DIV_ST-1][k]) * MUL_W'(r_side[S_MUL-1].depth);
            end
            if (w_rdy[S_RND]) begin
                r_ray[k] <= n_ray[k];
            end
        end
        if (w_rdy[S_NORM0]) begin
            r_shr <= n_shr;
            r_sha <= n_sha;
        end
        if (w_rdy[S_SUM]) begin
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        end
        for (int j = 0; j < SQRT_ST; j++) begin
            if (w_rdy[S_SQRT+j]) begin
                r_sqn[j] <= n_sqn[j];
                r_sqr[j] <= n_sqr[j];
                r_sqq[j] <= n_sqq[j];
            end
        end
        for (int j = 0; j < DIV_ST; j++) begin
            if (w_rdy[S_DIV+j]) begin
                r_dlen[j] <= n_dlen[j];
                for (int k = 0; k < 3; k++) begin
                    r_drem[j][k] <= n_drem[j][k];
                    r_dq[j][k]   <= n_dq[j][k];
                end
            end
        end
        if (w_rdy[S_OUT]) begin
            r_out.world_x <= n_world[0];
            r_out.world_y <= n_world[1];
            r_out.world_z <= n_world[2];
        end
    end

    assign o_out_item = r_out;

`ifndef SYNTH
    a_empty_out_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready with empty output stage");

    a_norm_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_NORM1] && !r_side[S_NORM1].zero) |->
        (r_side[S_NORM1].nm[0][NM_W-1] || r_side[S_NORM1].nm[1][NM_W-1]
         || r_side[S_NORM1].nm[2][NM_W-1]))
        else $error("normalised largest component out of range");

    a_root_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_DIV-1] && !r_side[S_DIV-1].zero) |->
        (r_sqq[SQRT_ST-1][ROOT_W-1:ROOT_W-2] != 2'b00))
        else $error("ray length below normalised range");

    a_unit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_MUL-1] && !r_side[S_MUL-1].zero) |->
        (r_dq[DIV_ST-1][0] <= (QU_W'(1) << (QU_W - 1))
         && r_dq[DIV_ST-1][1] <= (QU_W'(1) << (QU_W - 1))
         && r_dq[DIV_ST-1][2] <= (QU_W'(1) << (QU_W - 1))))
        else $error("unit component above one");
`endif

endmodule
